// ===== rtl/mnta_pkg.sv =====
// Package for the masked neighbor temperature average block.
// Holds defaults, register indexes and the controller/datapath signal groups.
// No dependencies.
`timescale 1ns / 1ps

package mnta_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int TEMP_BITS_DEF = 16;
   localparam int MAX_HEIGHT    = 1024;

   localparam int SIZE_BITS  = 11;
   localparam int POS_BITS   = 10;
   localparam int ELEM_BITS  = 16;
   localparam int FTEMP_BITS = 16;
   localparam int CSR_IDX_BITS = 8;
   localparam int CSR_DAT_BITS = 16;

   localparam logic [SIZE_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
   localparam logic [SIZE_BITS-1:0] GRID_HEIGHT_RST = 11'd1024;
   localparam logic [ELEM_BITS-1:0] CENTER_RST      = 16'd0;
   localparam logic [ELEM_BITS-1:0] BARRIER_RST     = 16'd1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_WIDTH      = 8'd0,
      CSR_GRID_HEIGHT     = 8'd1,
      CSR_CENTER_ELEMENT  = 8'd2,
      CSR_BARRIER_ELEMENT = 8'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch input transfer, start line store read
      logic update;    // shift window, write line stores, advance position
      logic sum;       // form neighbor sum and count, start divider
      logic out_load;  // load the result register
   } cmd_type;

   // Status from the datapath and divider to the controller.
   typedef struct packed {
      logic emit;      // current cell yields a result
      logic div_done;  // divider finishes this cycle
      logic rsp_free;  // result register may take a new result
   } sts_type;

endpackage

// ===== rtl/mnta_ifs.sv =====
// Channel interfaces: cell input, result output and register write.
// Depends on mnta_pkg.
`timescale 1ns / 1ps

interface mnta_req_if
   import mnta_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [ELEM_BITS-1:0]  element_index;
   logic                  has_mass;
   logic [FTEMP_BITS-1:0] temperature;
   modport source (output valid, element_index, has_mass, temperature, input ready);
   modport sink   (input valid, element_index, has_mass, temperature, output ready);
endinterface

interface mnta_rsp_if
   import mnta_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [POS_BITS-1:0]   cell_x;
   logic [POS_BITS-1:0]   cell_y;
   logic                  averaged;
   logic [FTEMP_BITS-1:0] new_temperature;
   logic                  frame_end;
   modport source (output valid, cell_x, cell_y, averaged, new_temperature, frame_end,
                   input ready);
   modport sink   (input valid, cell_x, cell_y, averaged, new_temperature, frame_end,
                   output ready);
endinterface

interface mnta_csr_if
   import mnta_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CSR_DAT_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mnta_div.sv =====
// Restoring divider of the neighbor sum by a count of 0..8, one bit a cycle.
// Depends on mnta_pkg.
`timescale 1ns / 1ps

module mnta_div
   import mnta_pkg::*;
#(
   parameter int TEMP_BITS = TEMP_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TEMP_BITS+2:0] dividend,
   input  logic [3:0]           divisor,
   output logic                 done,
   output logic [TEMP_BITS+2:0] quotient
);
   localparam int SW   = TEMP_BITS + 3;
   localparam int CNTW = $clog2(SW + 1);

   logic            busy_ff;
   logic [CNTW-1:0] step_ff;
   logic [SW-1:0]   quo_ff, quo_in;
   logic [3:0]      rem_ff, rem_in;
   logic [3:0]      dvs_ff;
   logic [4:0]      trial;
   logic            ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial  = {rem_ff, quo_ff[SW-1]};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? 4'(trial - {1'b0, dvs_ff}) : trial[3:0];
      quo_in = {quo_ff[SW-2:0], ge};
   end

   assign done     = busy_ff && (step_ff == CNTW'(SW - 1));
   assign quotient = quo_ff;

   // Hold control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (done) busy_ff <= 1'b0;
         step_ff <= step_ff + 1'b1;
      end
   end

   // Advance the operands.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== rtl/mnta_ctrl.sv =====
// Controller state machine: sequences capture, window update, sum, divide, output.
// Depends on mnta_pkg.
`timescale 1ns / 1ps

module mnta_ctrl
   import mnta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_UPDATE, S_SUM, S_DIV, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // Decode commands and next state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = sts.emit ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_capture_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.update) else $error("capture not followed by update");
   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.rsp_free) else $error("result register overwritten");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == S_DIV) else $error("divider done outside divide");
   a_sum_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.sum |-> $past(cmd.update) && $past(sts.emit)) else $error("sum without result");

endmodule

// ===== rtl/mnta_dp.sv =====
// Datapath: line stores, 3x3 window, raster position, neighbor sum, result register.
// Depends on mnta_pkg; the divider is outside and fed through ports.
`timescale 1ns / 1ps

module mnta_dp
   import mnta_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int TEMP_BITS = TEMP_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [SIZE_BITS-1:0]  width,
   input  logic [SIZE_BITS-1:0]  height,
   input  logic [ELEM_BITS-1:0]  center,
   input  logic [ELEM_BITS-1:0]  barrier,
   input  logic [ELEM_BITS-1:0]  in_elem,
   input  logic                  in_mass,
   input  logic [FTEMP_BITS-1:0] in_temp,
   output logic                  emit,
   output logic                  rsp_free,
   output logic [TEMP_BITS+2:0]  div_dividend,
   output logic [3:0]            div_divisor,
   input  logic [TEMP_BITS+2:0]  div_quotient,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POS_BITS-1:0]   rsp_cell_x,
   output logic [POS_BITS-1:0]   rsp_cell_y,
   output logic                  rsp_averaged,
   output logic [FTEMP_BITS-1:0] rsp_new_temperature,
   output logic                  rsp_frame_end
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int SW = TEMP_BITS + 3;

   typedef struct packed {
      logic [ELEM_BITS-1:0] elem;
      logic                 mass;
      logic [TEMP_BITS-1:0] temp;
   } cell_type;

   cell_type upper_mem [MAX_WIDTH];
   cell_type lower_mem [MAX_WIDTH];
   cell_type up_rd_ff, lo_rd_ff, in_ff, incoming;
   cell_type win_ff [3][3];

   logic [POS_BITS-1:0]  col_ff, row_ff, col_in, row_in;
   logic [POS_BITS-1:0]  x_ff, y_ff;
   logic [SIZE_BITS-1:0] x_next, y_next;
   logic [AW-1:0]        rd_col, wr_col;
   logic                 in_frame;
   logic                 avg_ff;
   logic [SW-1:0]        sum;
   logic [3:0]           cnt;

   logic                  rsp_valid_ff;
   logic [POS_BITS-1:0]   cell_x_ff, cell_y_ff;
   logic                  averaged_ff;
   logic [FTEMP_BITS-1:0] new_temp_ff;
   logic                  frame_end_ff;

   // Incoming temperature is kept at the internal width.
   always_comb begin
      incoming.elem = in_elem;
      incoming.mass = in_mass;
      incoming.temp = TEMP_BITS'(in_temp);
   end

   assign rd_col   = AW'(col_ff);
   assign wr_col   = AW'(x_ff);
   assign in_frame = (SIZE_BITS'(x_ff) < width) && (SIZE_BITS'(y_ff) < height);
   assign emit     = in_frame && (x_ff >= POS_BITS'(2)) && (y_ff >= POS_BITS'(2));

   // Next raster position: wrap column at width, row at height.
   always_comb begin
      x_next = SIZE_BITS'(x_ff) + 1'b1;
      y_next = SIZE_BITS'(y_ff);
      if (x_next >= width) begin
         x_next = '0;
         y_next = y_next + 1'b1;
      end
      if (y_next >= height) y_next = '0;
      col_in = x_next[POS_BITS-1:0];
      row_in = y_next[POS_BITS-1:0];
   end

   // Capture the input transfer and read both line stores at its column.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff    <= incoming;
         x_ff     <= col_ff;
         y_ff     <= row_ff;
         up_rd_ff <= upper_mem[rd_col];
         lo_rd_ff <= lower_mem[rd_col];
      end
      if (cmd.update && in_frame) begin
         upper_mem[wr_col] <= lo_rd_ff;
         lower_mem[wr_col] <= in_ff;
      end
   end

   // Advance position and shift the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
      end else if (cmd.update) begin
         col_ff <= col_in;
         row_ff <= row_in;
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         if (in_frame) begin
            win_ff[0][2] <= up_rd_ff;
            win_ff[1][2] <= lo_rd_ff;
            win_ff[2][2] <= in_ff;
         end
      end
   end

   // Sum and count the qualifying neighbors.
   always_comb begin
      sum = '0;
      cnt = '0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            if (!(r == 1 && c == 1) && win_ff[r][c].elem != center &&
                win_ff[r][c].elem != barrier && win_ff[r][c].mass) begin
               sum = sum + SW'(win_ff[r][c].temp);
               cnt = cnt + 1'b1;
            end
   end

   assign div_dividend = sum;
   assign div_divisor  = cnt;

   always_ff @(posedge clock) begin
      if (cmd.sum) avg_ff <= (win_ff[1][1].elem == center) && (cnt != 4'd0);
   end

   // Result register: load when done, drop on transfer.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         cell_x_ff    <= x_ff - 1'b1;
         cell_y_ff    <= y_ff - 1'b1;
         averaged_ff  <= avg_ff;
         new_temp_ff  <= avg_ff ? FTEMP_BITS'(div_quotient[TEMP_BITS-1:0]) : '0;
         frame_end_ff <= (SIZE_BITS'(x_ff) == width - 1'b1) &&
                         (SIZE_BITS'(y_ff) == height - 1'b1);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_x          = cell_x_ff;
   assign rsp_cell_y          = cell_y_ff;
   assign rsp_averaged        = averaged_ff;
   assign rsp_new_temperature = new_temp_ff;
   assign rsp_frame_end       = frame_end_ff;

endmodule

// ===== rtl/masked_neighbor_temperature_average.sv =====
// Top level: register file, controller, datapath and divider.
// Depends on mnta_pkg, mnta_ifs, mnta_ctrl, mnta_dp, mnta_div.
//
//   channel  direction  fields
//   req_ch   in         element_index, has_mass, temperature
//   rsp_ch   out        cell_x, cell_y, averaged, new_temperature, frame_end
//   csr_ch   in         index, data (always ready)
//
// A cell that yields no result passes capture and window update; one that yields a result
// also passes the sum, the one-bit-a-cycle divider and the output load.
// A new cell is taken while a finished result still waits in the output register.
// A stalled result holds the block in its last step until taken.
// Reset (synchronous) clears position, window and registers; line stores stay undefined.
`timescale 1ns / 1ps

module masked_neighbor_temperature_average
   import mnta_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int TEMP_BITS = TEMP_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   mnta_req_if.sink   req_ch,
   mnta_rsp_if.source rsp_ch,
   mnta_csr_if.sink   csr_ch
);
   logic [SIZE_BITS-1:0] gw_ff, gh_ff, width, height;
   logic [ELEM_BITS-1:0] center_ff, barrier_ff;
   cmd_type              cmd;
   sts_type              sts;
   logic                 emit, rsp_free, div_done;
   logic [TEMP_BITS+2:0] dividend, quotient;
   logic [3:0]           divisor;

   assign csr_ch.ready = 1'b1;

   // Hold configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff      <= GRID_WIDTH_RST;
         gh_ff      <= GRID_HEIGHT_RST;
         center_ff  <= CENTER_RST;
         barrier_ff <= BARRIER_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_GRID_WIDTH:      gw_ff      <= csr_ch.data[SIZE_BITS-1:0];
            CSR_GRID_HEIGHT:     gh_ff      <= csr_ch.data[SIZE_BITS-1:0];
            CSR_CENTER_ELEMENT:  center_ff  <= csr_ch.data;
            CSR_BARRIER_ELEMENT: barrier_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Saturate the frame size.
   always_comb begin
      if (gw_ff < SIZE_BITS'(3))             width = SIZE_BITS'(3);
      else if (32'(gw_ff) > MAX_WIDTH)       width = SIZE_BITS'(MAX_WIDTH);
      else                                   width = gw_ff;
      if (gh_ff < SIZE_BITS'(3))             height = SIZE_BITS'(3);
      else if (32'(gh_ff) > MAX_HEIGHT)      height = SIZE_BITS'(MAX_HEIGHT);
      else                                   height = gh_ff;
   end

   always_comb begin
      sts.emit     = emit;
      sts.div_done = div_done;
      sts.rsp_free = rsp_free;
   end

   mnta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mnta_dp #(.MAX_WIDTH(MAX_WIDTH), .TEMP_BITS(TEMP_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .width               (width),
      .height              (height),
      .center              (center_ff),
      .barrier             (barrier_ff),
      .in_elem             (req_ch.element_index),
      .in_mass             (req_ch.has_mass),
      .in_temp             (req_ch.temperature),
      .emit                (emit),
      .rsp_free            (rsp_free),
      .div_dividend        (dividend),
      .div_divisor         (divisor),
      .div_quotient        (quotient),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_cell_x          (rsp_ch.cell_x),
      .rsp_cell_y          (rsp_ch.cell_y),
      .rsp_averaged        (rsp_ch.averaged),
      .rsp_new_temperature (rsp_ch.new_temperature),
      .rsp_frame_end       (rsp_ch.frame_end)
   );

   mnta_div #(.TEMP_BITS(TEMP_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sum),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule

// ===== tb/sv/tb_masked_neighbor_temperature_average.sv =====
// Testbench for masked_neighbor_temperature_average: streams raster frames of cells,
// predicts each interior cell's masked neighbor mean in a scoreboard class and checks results.
// Depends on mnta_pkg, mnta_ifs and the block's RTL.
`timescale 1ns / 1ps

module tb_masked_neighbor_temperature_average;
   import mnta_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 40;
   localparam int LINE_DEPTH  = 1024;

   typedef struct packed {
      logic [ELEM_BITS-1:0]  elem;
      logic                  mass;
      logic [FTEMP_BITS-1:0] temp;
   } cell_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   x;
      logic [POS_BITS-1:0]   y;
      logic                  averaged;
      logic [FTEMP_BITS-1:0] temp;
      logic                  frame_end;
   } mean_type;

   // Neighbor mean predictor with its own line stores, window and position.
   class mean_scoreboard;
      cell_type upper[LINE_DEPTH];
      cell_type lower[LINE_DEPTH];
      cell_type win[3][3];
      int unsigned col, row;
      logic [SIZE_BITS-1:0] width, height;
      logic [ELEM_BITS-1:0] center, barrier;
      mean_type due[$];
      int errors;

      function new();
         width = GRID_WIDTH_RST;
         height = GRID_HEIGHT_RST;
         center = CENTER_RST;
         barrier = BARRIER_RST;
         col = 0;
         row = 0;
         errors = 0;
         foreach (win[r, c]) win[r][c] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DAT_BITS-1:0] d);
         case (idx)
            CSR_GRID_WIDTH:      width = d[SIZE_BITS-1:0];
            CSR_GRID_HEIGHT:     height = d[SIZE_BITS-1:0];
            CSR_CENTER_ELEMENT:  center = d;
            CSR_BARRIER_ELEMENT: barrier = d;
            default: ;
         endcase
      endfunction

      function int unsigned eff_w();
         return (width < 3) ? 3 : ((width > LINE_DEPTH) ? LINE_DEPTH : width);
      endfunction

      function int unsigned eff_h();
         return (height < 3) ? 3 : ((height > MAX_HEIGHT) ? MAX_HEIGHT : height);
      endfunction

      function bit frame_start();
         return col == 0 && row == 0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      // Advance the window by one accepted cell and queue the result it completes.
      function void note_cell(cell_type c);
         int unsigned w, h, sum, cnt;
         bit in_frame;
         mean_type m;
         w = eff_w();
         h = eff_h();
         in_frame = (col < w) && (row < h);
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         if (in_frame) begin
            win[0][2] = upper[col];
            win[1][2] = lower[col];
            win[2][2] = c;
            upper[col] = lower[col];
            lower[col] = c;
         end
         if (in_frame && col >= 2 && row >= 2) begin
            sum = 0;
            cnt = 0;
            m = '0;
            if (win[1][1].elem == center) begin
               foreach (win[r, k]) begin
                  if (!(r == 1 && k == 1) && win[r][k].elem != center &&
                      win[r][k].elem != barrier && win[r][k].mass) begin
                     sum += win[r][k].temp;
                     cnt++;
                  end
               end
               if (cnt > 0) begin
                  m.averaged = 1'b1;
                  m.temp = FTEMP_BITS'(sum / cnt);
               end
            end
            m.x = POS_BITS'(col - 1);
            m.y = POS_BITS'(row - 1);
            m.frame_end = (col == w - 1) && (row == h - 1);
            due = {due, m};
         end
         col++;
         if (col >= w) begin
            col = 0;
            row++;
         end
         if (row >= h) row = 0;
      endfunction

      // Compare one result transfer with the oldest expected mean.
      function void check_result(mean_type got);
         mean_type exp_m;
         if (due.size() == 0) begin
            $error("unexpected result at x=%0d y=%0d", got.x, got.y);
            errors++;
            return;
         end
         exp_m = due.pop_front();
         if (got.x !== exp_m.x) begin
            $error("cell_x: expected %0d, got %0d", exp_m.x, got.x);
            errors++;
         end
         if (got.y !== exp_m.y) begin
            $error("cell_y: expected %0d, got %0d", exp_m.y, got.y);
            errors++;
         end
         if (got.averaged !== exp_m.averaged) begin
            $error("averaged: expected %0d, got %0d", exp_m.averaged, got.averaged);
            errors++;
         end
         if (got.temp !== exp_m.temp) begin
            $error("new_temperature: expected %0d, got %0d", exp_m.temp, got.temp);
            errors++;
         end
         if (got.frame_end !== exp_m.frame_end) begin
            $error("frame_end: expected %0d, got %0d", exp_m.frame_end, got.frame_end);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   sent;
   int   stall_count;
   mean_scoreboard sb;

   mnta_req_if req_ch();
   mnta_rsp_if rsp_ch();
   mnta_csr_if csr_ch();

   masked_neighbor_temperature_average i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Check result transfers and stall the result side at random.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.cell_x, rsp_ch.cell_y, rsp_ch.averaged,
                          rsp_ch.new_temperature, rsp_ch.frame_end});
      rsp_ch.ready <= steady || ($urandom_range(99) >= 12);
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DAT_BITS-1:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.write_reg(idx, d);
   endtask

   // Hold one cell on the input until its transfer, idling before it at random.
   task automatic send_cell(cell_type c);
      if (!steady && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.element_index <= c.elem;
      req_ch.has_mass      <= c.mass;
      req_ch.temperature   <= c.temp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_cell(c);
      sent++;
   endtask

   // Drain all expected results, then let the divider settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [ELEM_BITS-1:0] pick_elem();
      case ($urandom_range(9))
         0, 1, 2, 3: return sb.center;
         4:          return sb.barrier;
         5, 6, 7:    return ELEM_BITS'($urandom_range(2, 5));
         8:          return ELEM_BITS'($urandom);
         default:    return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   function automatic cell_type random_cell();
      cell_type c;
      c.elem = pick_elem();
      c.mass = ($urandom_range(9) < 7);
      case ($urandom_range(9))
         0:       c.temp = '0;
         1:       c.temp = '1;
         default: c.temp = FTEMP_BITS'($urandom);
      endcase
      return c;
   endfunction

   // Directed 3x3 frame: full-scale mean, mixed exclusions, no qualifying neighbor.
   task automatic directed_frame(int kind);
      cell_type c;
      for (int i = 0; i < 9; i++) begin
         c = '{elem: 16'd2, mass: 1'b1, temp: 16'hFFFF};
         if (i == 4) c.elem = 16'd7;
         else if (kind == 1) begin
            case (i)
               0, 1:    c.elem = 16'd9;
               2, 3:    c.elem = 16'd7;
               5:       c.mass = 1'b0;
               default: c.temp = FTEMP_BITS'(i - 6);
            endcase
         end else if (kind == 2) begin
            c.elem = (i < 4) ? 16'd9 : 16'd3;
            c.mass = (i < 4);
         end
         send_cell(c);
      end
   endtask

   task automatic random_frames(int frames);
      repeat (frames)
         repeat (sb.eff_w() * sb.eff_h()) send_cell(random_cell());
   endtask

   task automatic random_setup(int max_w, int max_h);
      write_reg(CSR_GRID_WIDTH, $urandom_range(9) == 0 ? CSR_DAT_BITS'($urandom_range(2)) :
                CSR_DAT_BITS'($urandom_range(3, max_w)));
      write_reg(CSR_GRID_HEIGHT, $urandom_range(9) == 0 ? CSR_DAT_BITS'($urandom_range(2)) :
                CSR_DAT_BITS'($urandom_range(3, max_h)));
      write_reg(CSR_CENTER_ELEMENT, $urandom_range(4) == 0 ? ($urandom_range(1) ? '1 : '0)
                : CSR_DAT_BITS'($urandom_range(0, 6)));
      write_reg(CSR_BARRIER_ELEMENT, $urandom_range(4) == 0 ? ($urandom_range(1) ? '1 : '0)
                : CSR_DAT_BITS'($urandom_range(0, 6)));
   endtask

   initial begin
      int phase;
      sb = new();
      reset  = 1'b1;
      steady = 1'b0;
      sent   = 0;
      req_ch.valid <= 1'b0;
      req_ch.element_index <= '0;
      req_ch.has_mass <= 1'b0;
      req_ch.temperature <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_GRID_WIDTH;
      csr_ch.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames; upper width bits are junk and must be masked off.
      write_reg(CSR_GRID_WIDTH, 16'hF803);
      write_reg(CSR_GRID_HEIGHT, 16'd3);
      write_reg(CSR_CENTER_ELEMENT, 16'd7);
      write_reg(CSR_BARRIER_ELEMENT, 16'd9);
      for (int k = 0; k < 3; k++) directed_frame(k);
      wait_idle();

      // Random frames on small grids, with one idle-free stretch.
      phase = 0;
      while (sent < 600) begin
         steady = (sent >= 150 && sent < 300);
         random_setup(8, 6);
         if (phase == 3) begin
            // Reshape mid-frame: shrink width, change height, run on to frame start.
            write_reg(CSR_GRID_WIDTH, 16'd8);
            write_reg(CSR_GRID_HEIGHT, 16'd6);
            random_frames(1);
            repeat (20) send_cell(random_cell());
            wait_idle();
            write_reg(CSR_GRID_WIDTH, CSR_DAT_BITS'($urandom_range(3, 6)));
            write_reg(CSR_GRID_HEIGHT, CSR_DAT_BITS'($urandom_range(3, 8)));
            while (!sb.frame_start()) send_cell(random_cell());
         end else begin
            random_frames($urandom_range(1, 3));
         end
         wait_idle();
         phase++;
      end
      steady = 1'b0;

      // Size extremes: both sizes saturated low, then part of a row at saturated high sizes.
      write_reg(CSR_GRID_WIDTH, 16'd1);
      write_reg(CSR_GRID_HEIGHT, 16'd0);
      random_frames(2);
      wait_idle();
      write_reg(CSR_GRID_WIDTH, 16'd2047);
      write_reg(CSR_GRID_HEIGHT, 16'd2047);
      repeat (30) send_cell(random_cell());
      wait_idle();
      write_reg(CSR_GRID_WIDTH, 16'd3);
      write_reg(CSR_GRID_HEIGHT, 16'd3);
      while (!sb.frame_start()) send_cell(random_cell());
      wait_idle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
